[hw/rtl/core_bandwidth_regulator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the core bandwidth regulator
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CORE_BANDWIDTH_REGULATOR_ASSERT_SVH
`define CORE_BANDWIDTH_REGULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBR_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hw/rtl/cbr_pkg.sv]
// ----------------------------------------------------------------------------
// cbr_pkg
// Types and constants shared by the bandwidth regulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbr_pkg;

  localparam int NUM_CORES = 4;

  localparam logic [30:0] RESET_BUDGET = 31'd1638400;

  typedef enum logic [1:0] {
    ACT_COUNT  = 2'd0,
    ACT_PERIOD = 2'd1,
    ACT_LIMIT  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/core_bandwidth_regulator.sv]
// Result: an accepted item is captured in the idle state, updated in the execute state and
// presented from the result registers in the response state.
// Flow: a new item is accepted only once the result of the last one has been taken;
// the capture, update and result states of the sequencer run in turn for each item.
// Reset: synchronous, active high; every core returns to its reset budget,
// averages and cleared totals together, with no clearing pass.
// ----------------------------------------------------------------------------
// core_bandwidth_regulator
// Per-core memory-miss budget regulator with throttling and period statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "core_bandwidth_regulator_assert.svh"

module core_bandwidth_regulator import cbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  core,
  input  logic [15:0] miss_increment,
  input  logic [30:0] new_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  core_out,
  output logic [3:0]  throttle_vector,
  output logic        became_throttled,
  output logic [31:0] period_used,
  output logic [31:0] average_half,
  output logic [31:0] average_quarter,
  output logic [30:0] active_budget,
  output logic [47:0] used_total,
  output logic [47:0] total_assigned,
  output logic [31:0] throttled_periods
);

  ctrl_cmd_t cmd;
  logic      in_accept;
  logic      out_became;

  cbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cbr_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .action            (action),
    .core              (core),
    .miss_increment    (miss_increment),
    .new_limit         (new_limit),
    .core_out          (core_out),
    .throttle_vector   (throttle_vector),
    .became_throttled  (became_throttled),
    .period_used       (period_used),
    .average_half      (average_half),
    .average_quarter   (average_quarter),
    .active_budget     (active_budget),
    .used_total        (used_total),
    .total_assigned    (total_assigned),
    .throttled_periods (throttled_periods)
  );

  assign in_accept  = in_valid && !in_stall;
  assign out_became = out_valid && became_throttled;

  `CBR_ASSERT_SAME(a_no_accept_with_result, !in_stall, !out_valid, "input open during result")
  `CBR_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall && !out_valid, "not busy after accept")
  `CBR_ASSERT_SAME(a_became_sets_bit, out_became, throttle_vector[core_out], "throttle bit missing")

endmodule

`default_nettype wire

[hw/rtl/cbr_ctrl.sv]
// ----------------------------------------------------------------------------
// cbr_ctrl
// Sequencer that captures an item, runs its update and presents the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbr_ctrl import cbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/cbr_datapath.sv]
// ----------------------------------------------------------------------------
// cbr_datapath
// Per-core budget state, period-close arithmetic and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbr_datapath import cbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  input  logic [1:0]  action,
  input  logic [1:0]  core,
  input  logic [15:0] miss_increment,
  input  logic [30:0] new_limit,
  output logic [1:0]  core_out,
  output logic [3:0]  throttle_vector,
  output logic        became_throttled,
  output logic [31:0] period_used,
  output logic [31:0] average_half,
  output logic [31:0] average_quarter,
  output logic [30:0] active_budget,
  output logic [47:0] used_total,
  output logic [47:0] total_assigned,
  output logic [31:0] throttled_periods
);

  logic [1:0]  act_q;
  logic [1:0]  core_q;
  logic [15:0] inc_q;
  logic [30:0] lim_q;

  logic [31:0] miss_count       [NUM_CORES];
  logic [30:0] budget           [NUM_CORES];
  logic [30:0] pending_limit    [NUM_CORES];
  logic [31:0] last_used        [NUM_CORES];
  logic [31:0] avg_half         [NUM_CORES];
  logic [31:0] avg_quarter      [NUM_CORES];
  logic [47:0] sum_used         [NUM_CORES];
  logic [47:0] sum_assigned     [NUM_CORES];
  logic [31:0] throttle_periods [NUM_CORES];
  logic [NUM_CORES-1:0] throttled;

  logic        in_range;
  logic [31:0] mc_cur;
  logic [30:0] bud_cur;
  logic [30:0] pl_cur;
  logic        thr_cur;
  logic [31:0] ah_cur;
  logic [31:0] aq_cur;
  logic [47:0] su_cur;
  logic [47:0] sa_cur;
  logic [31:0] tp_cur;

  logic [32:0] mc_sum;
  logic [31:0] mc_cnt;
  logic [32:0] ah_sum;
  logic [33:0] aq_three;
  logic [34:0] aq_sum;
  logic [48:0] su_sum;
  logic [48:0] sa_sum;

  logic [31:0] mc_next;
  logic [30:0] bud_next;
  logic [30:0] pl_next;
  logic        thr_next;
  logic [31:0] lu_next;
  logic [31:0] ah_next;
  logic [31:0] aq_next;
  logic [47:0] su_next;
  logic [47:0] sa_next;
  logic [31:0] tp_next;
  logic        became_next;
  logic [NUM_CORES-1:0] thr_vec_next;
  logic [3:0]  tv_next;

  assign in_range = (32'(core_q) < 32'(NUM_CORES));

  assign mc_cur  = miss_count[core_q];
  assign bud_cur = budget[core_q];
  assign pl_cur  = pending_limit[core_q];
  assign thr_cur = throttled[core_q];
  assign ah_cur  = avg_half[core_q];
  assign aq_cur  = avg_quarter[core_q];
  assign su_cur  = sum_used[core_q];
  assign sa_cur  = sum_assigned[core_q];
  assign tp_cur  = throttle_periods[core_q];

  assign mc_sum   = {1'b0, mc_cur} + {17'b0, inc_q};
  assign mc_cnt   = mc_sum[32] ? 32'hFFFF_FFFF : mc_sum[31:0];
  assign ah_sum   = {1'b0, ah_cur} + {1'b0, mc_cur};
  assign aq_three = {2'b0, aq_cur} + {1'b0, aq_cur, 1'b0};
  assign aq_sum   = {1'b0, aq_three} + {3'b0, mc_cur};
  assign su_sum   = {1'b0, su_cur} + {17'b0, mc_cur};
  assign sa_sum   = {1'b0, sa_cur} + {18'b0, bud_cur};

  always_comb begin
    mc_next     = mc_cur;
    bud_next    = bud_cur;
    pl_next     = pl_cur;
    thr_next    = thr_cur;
    lu_next     = last_used[core_q];
    ah_next     = ah_cur;
    aq_next     = aq_cur;
    su_next     = su_cur;
    sa_next     = sa_cur;
    tp_next     = tp_cur;
    became_next = 1'b0;
    case (action_t'(act_q))
      ACT_COUNT: begin
        mc_next = mc_cnt;
        if (!thr_cur && (mc_cnt >= {1'b0, bud_cur})) begin
          thr_next    = 1'b1;
          became_next = 1'b1;
        end
      end
      ACT_PERIOD: begin
        if (thr_cur && (tp_cur != 32'hFFFF_FFFF)) tp_next = tp_cur + 32'd1;
        thr_next = 1'b0;
        lu_next  = mc_cur;
        ah_next  = ah_sum[32:1];
        aq_next  = aq_sum[33:2];
        su_next  = su_sum[48] ? 48'hFFFF_FFFF_FFFF : su_sum[47:0];
        sa_next  = sa_sum[48] ? 48'hFFFF_FFFF_FFFF : sa_sum[47:0];
        bud_next = (pl_cur == 31'd0) ? 31'd1 : pl_cur;
        mc_next  = 32'd0;
      end
      ACT_LIMIT: begin
        if (lim_q != 31'd0) pl_next = lim_q;
      end
      ACT_READ: begin
        mc_next = mc_cur;
      end
      default: begin
        mc_next = mc_cur;
      end
    endcase
  end

  always_comb begin
    thr_vec_next = throttled;
    if (in_range) thr_vec_next[core_q] = thr_next;
    tv_next = 4'd0;
    for (int b = 0; b < 4; b++) begin
      if (b < NUM_CORES) tv_next[b] = thr_vec_next[b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action;
      core_q <= core;
      inc_q  <= miss_increment;
      lim_q  <= new_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttled <= '0;
      for (int c = 0; c < NUM_CORES; c++) begin
        miss_count[c]       <= 32'd0;
        budget[c]           <= RESET_BUDGET;
        pending_limit[c]    <= RESET_BUDGET;
        last_used[c]        <= {1'b0, RESET_BUDGET};
        avg_half[c]         <= {1'b0, RESET_BUDGET};
        avg_quarter[c]      <= {1'b0, RESET_BUDGET};
        sum_used[c]         <= 48'd0;
        sum_assigned[c]     <= 48'd0;
        throttle_periods[c] <= 32'd0;
      end
    end else if (cmd.execute && in_range) begin
      throttled                <= thr_vec_next;
      miss_count[core_q]       <= mc_next;
      budget[core_q]           <= bud_next;
      pending_limit[core_q]    <= pl_next;
      last_used[core_q]        <= lu_next;
      avg_half[core_q]         <= ah_next;
      avg_quarter[core_q]      <= aq_next;
      sum_used[core_q]         <= su_next;
      sum_assigned[core_q]     <= sa_next;
      throttle_periods[core_q] <= tp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      core_out        <= core_q;
      throttle_vector <= tv_next;
      if (in_range) begin
        became_throttled  <= became_next;
        period_used       <= lu_next;
        average_half      <= ah_next;
        average_quarter   <= aq_next;
        active_budget     <= bud_next;
        used_total        <= su_next;
        total_assigned    <= sa_next;
        throttled_periods <= tp_next;
      end else begin
        became_throttled  <= 1'b0;
        period_used       <= 32'd0;
        average_half      <= 32'd0;
        average_quarter   <= 32'd0;
        active_budget     <= 31'd0;
        used_total        <= 48'd0;
        total_assigned    <= 48'd0;
        throttled_periods <= 32'd0;
      end
    end
  end

endmodule

`default_nettype wire
